// ===== design/msp_pkg.sv =====
// Shared types and register codes for the mid/side polynomial predictor.
`default_nettype none

package msp_pkg;

   // Configuration register indexes (byte address is four times the index).
   localparam logic REG_ORDER = 1'b0;
   localparam logic REG_SHIFT = 1'b1;

   localparam int ORDER_BITS = 2;
   localparam int SHIFT_BITS = 4;

   // Predictor order codes; any other code acts as order three.
   localparam logic [ORDER_BITS-1:0] ORDER_ONE   = 2'd1;
   localparam logic [ORDER_BITS-1:0] ORDER_TWO   = 2'd2;
   localparam logic [ORDER_BITS-1:0] ORDER_THREE = 2'd3;

   localparam logic [ORDER_BITS-1:0] ORDER_RESET = ORDER_ONE;
   localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 4'd0;

   typedef struct packed {
      logic [ORDER_BITS-1:0] order;
      logic [SHIFT_BITS-1:0] shift;
   } msp_cfg_type;

endpackage

`default_nettype wire

// ===== design/msp_if.sv =====
// Request and response channel interfaces of the mid/side predictor.
`default_nettype none

interface msp_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface msp_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                            valid;
   logic                            ready;
   logic signed [SAMPLE_BITS+2:0]   mid_residual;
   logic signed [SAMPLE_BITS+2:0]   side_residual;

   modport source (output valid, output mid_residual, output side_residual, input ready);
   modport sink   (input valid, input mid_residual, input side_residual, output ready);
endinterface

`default_nettype wire

// ===== design/msp_csr.sv =====
// APB-style configuration registers for predictor order and quantization shift.
`default_nettype none

module msp_csr
   import msp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready,
   output      msp_cfg_type cfg
);

   msp_cfg_type cfg_ff, cfg_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_ORDER: cfg_in.order = csr_pwdata[ORDER_BITS-1:0];
            REG_SHIFT: cfg_in.shift = csr_pwdata[SHIFT_BITS-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_ORDER: csr_prdata = {{(32-ORDER_BITS){1'b0}}, cfg_ff.order};
         REG_SHIFT: csr_prdata = {{(32-SHIFT_BITS){1'b0}}, cfg_ff.shift};
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.order <= ORDER_RESET;
         cfg_ff.shift <= SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/msp_split.sv =====
// Mid/side decorrelation of one stereo frame.
`default_nettype none

module msp_split #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
   output      logic signed [SAMPLE_BITS-1:0] mid_sample,
   output      logic signed [SAMPLE_BITS-1:0] side_sample
);

   logic signed [SAMPLE_BITS:0] sum;
   logic signed [SAMPLE_BITS:0] sum_adj;
   logic signed [SAMPLE_BITS:0] diff;

   assign sum  = {left_sample[SAMPLE_BITS-1], left_sample}
               + {right_sample[SAMPLE_BITS-1], right_sample};
   // A negative odd sum is nudged up by one so the halving truncates toward zero.
   assign sum_adj = sum + {{SAMPLE_BITS{1'b0}}, sum[SAMPLE_BITS] & sum[0]};
   assign mid_sample = sum_adj[SAMPLE_BITS:1];

   assign diff = {left_sample[SAMPLE_BITS-1], left_sample}
               - {right_sample[SAMPLE_BITS-1], right_sample};
   assign side_sample = diff[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ===== design/msp_chan.sv =====
// One channel of fixed polynomial prediction with residual quantization and history.
`default_nettype none

module msp_chan
   import msp_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire msp_cfg_type                   cfg,
   input  wire logic [ORDER_BITS-1:0]         warmup_count,
   output      logic signed [SAMPLE_BITS+2:0] residual
);

   localparam int PW = SAMPLE_BITS + 3;   // prediction width
   localparam int DW = SAMPLE_BITS + 4;   // difference width

   logic signed [SAMPLE_BITS-1:0] hist0_ff, hist1_ff, hist2_ff;
   logic signed [SAMPLE_BITS-1:0] rebuilt;
   logic signed [PW-1:0]          h0, h1, h2;
   logic signed [PW-1:0]          pred_raw;
   logic signed [PW-1:0]          pred;
   logic [ORDER_BITS-1:0]         eff_order;
   logic signed [DW-1:0]          diff;
   logic signed [DW-1:0]          quant;
   logic signed [DW-1:0]          recon;

   assign h0 = PW'(hist0_ff);
   assign h1 = PW'(hist1_ff);
   assign h2 = PW'(hist2_ff);

   always_comb begin
      case (cfg.order)
         ORDER_ONE: begin
            eff_order = ORDER_ONE;
            pred_raw  = h0;
         end
         ORDER_TWO: begin
            eff_order = ORDER_TWO;
            pred_raw  = (h0 <<< 1) - h1;
         end
         default: begin
            eff_order = ORDER_THREE;
            pred_raw  = (h0 <<< 1) + h0 - (h1 <<< 1) - h1 + h2;
         end
      endcase
   end

   // Until enough frames have been seen the prediction is zero.
   assign pred  = (warmup_count < eff_order) ? '0 : pred_raw;
   assign diff  = DW'(sample) - DW'(pred);
   assign quant = diff >>> cfg.shift;
   assign recon = (quant <<< cfg.shift) + DW'(pred);

   assign rebuilt  = recon[SAMPLE_BITS-1:0];
   assign residual = quant[SAMPLE_BITS+2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         hist0_ff <= '0;
         hist1_ff <= '0;
         hist2_ff <= '0;
      end else if (step) begin
         hist2_ff <= hist1_ff;
         hist1_ff <= hist0_ff;
         hist0_ff <= rebuilt;
      end
   end

endmodule

`default_nettype wire

// ===== design/mid_side_polynomial_predictor_core.sv =====
// Top level of the mid/side polynomial predictor with quantized residuals.
`default_nettype none

// Channel   Direction  Handshake       Carries
// req       in         valid/ready     left_sample, right_sample
// rsp       out        valid/ready     mid_residual, side_residual
// csr_*     in/out     APB-style       predictor_order (0x0), quant_shift (0x4)
//
// Each request is held in the input register and is then coded into the result
// register, from which its response is offered on rsp until rsp.ready takes it.
// One request is accepted every cycle while rsp does not stall; the history update
// of both channels is the loop that sets this rate.
// A synchronous reset clears the histories, the warm-up count, both valid flags
// and the configuration registers (order one, shift zero).
// When rsp is stalled the result register holds and the input register keeps
// one more request, after which req.ready drops.

module mid_side_polynomial_predictor_core
   import msp_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   msp_req_if.sink          req,
   msp_rsp_if.source        rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam int RES_BITS = SAMPLE_BITS + 3;

   msp_cfg_type cfg;

   // Input register stage.
   logic                          in_valid_ff;
   logic signed [SAMPLE_BITS-1:0] left_ff;
   logic signed [SAMPLE_BITS-1:0] right_ff;

   // Result register stage.
   logic                          out_valid_ff;
   logic signed [RES_BITS-1:0]    mid_res_ff;
   logic signed [RES_BITS-1:0]    side_res_ff;

   logic [ORDER_BITS-1:0]         warmup_ff, warmup_in;
   logic                          advance;
   logic                          step;
   logic signed [SAMPLE_BITS-1:0] mid_sample;
   logic signed [SAMPLE_BITS-1:0] side_sample;
   logic signed [RES_BITS-1:0]    mid_res;
   logic signed [RES_BITS-1:0]    side_res;

   msp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The result register can take a new value when it is empty or being drained.
   assign advance   = !out_valid_ff || rsp.ready;
   // A request is coded, and the histories move, when it leaves the input register.
   assign step      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;

   // The warm-up count saturates at three frames.
   assign warmup_in = (warmup_ff == ORDER_THREE) ? warmup_ff : warmup_ff + 2'd1;

   msp_split #(.SAMPLE_BITS(SAMPLE_BITS)) u_split (
      .left_sample  (left_ff),
      .right_sample (right_ff),
      .mid_sample   (mid_sample),
      .side_sample  (side_sample)
   );

   msp_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_mid (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .sample       (mid_sample),
      .cfg          (cfg),
      .warmup_count (warmup_ff),
      .residual     (mid_res)
   );

   msp_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_side (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .sample       (side_sample),
      .cfg          (cfg),
      .warmup_count (warmup_ff),
      .residual     (side_res)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         warmup_ff    <= '0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step) begin
            warmup_ff <= warmup_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         left_ff  <= req.left_sample;
         right_ff <= req.right_sample;
      end
      if (step) begin
         mid_res_ff  <= mid_res;
         side_res_ff <= side_res;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.mid_residual  = mid_res_ff;
   assign rsp.side_residual = side_res_ff;

endmodule

`default_nettype wire
